>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> rtl/cdst_pkg.sv
`timescale 1ns / 1ps
package cdst_pkg;

  localparam int WIDTH_DEF  = 16;
  localparam int HEIGHT_DEF = 2;

  localparam int ROW_W   = 2;
  localparam int COL_W   = 5;
  localparam int GLYPH_W = 8;

  localparam logic [GLYPH_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [GLYPH_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_SETPOS = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } pos_t;

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] base;
    pos_t             cursor;
  } draw_req_t;

  // map a logical screen row onto the rotating physical row
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] height);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= {1'b0, height}) begin
      sum = sum - {1'b0, height};
    end
    return sum[ROW_W-1:0];
  endfunction

endpackage

>>> rtl/cdst_ram.sv
`timescale 1ns / 1ps
module cdst_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cdst_edit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdst_edit #(
  parameter int WIDTH  = cdst_pkg::WIDTH_DEF,
  parameter int HEIGHT = cdst_pkg::HEIGHT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cdst_pkg::GLYPH_W-1:0]          rx_byte_i,
  input  logic                                  done_i,
  output cdst_pkg::draw_req_t                   req_o,
  output logic [HEIGHT*WIDTH-1:0]               vld_o,
  output logic                                  ram_we_o,
  output logic [$clog2(HEIGHT*WIDTH)-1:0]       ram_waddr_o,
  output logic [cdst_pkg::GLYPH_W-1:0]          ram_wdata_o
);
  import cdst_pkg::*;

  localparam int DEPTH  = HEIGHT * WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PH_W   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int CC_W   = $clog2(WIDTH);

  logic              busy_q, busy_d;
  logic              start_q;
  logic [PH_W-1:0]   base_q, base_d;
  logic [PH_W-1:0]   row_q, row_d;
  logic [CC_W-1:0]   col_q, col_d;
  logic [DEPTH-1:0]  vld_q, vld_d;

  logic              accept;
  logic              is_cr;
  logic              wrap;
  logic              at_last_row;
  logic [ROW_W-1:0]  phys_full;
  logic [PH_W-1:0]   phys;
  logic [PH_W-1:0]   base_next;
  logic [ADDR_W-1:0] waddr;

  assign accept      = in_valid_i && !busy_q;
  assign in_stall_o  = busy_q;
  assign is_cr       = (rx_byte_i == CHAR_CR);
  assign wrap        = is_cr || (col_q == CC_W'(WIDTH - 1));
  assign at_last_row = (row_q == PH_W'(HEIGHT - 1));
  assign base_next   = (base_q == PH_W'(HEIGHT - 1)) ? '0 : base_q + PH_W'(1);

  assign phys_full = phys_row(ROW_W'(base_q), ROW_W'(row_q), ROW_W'(HEIGHT));
  assign phys      = phys_full[PH_W-1:0];
  assign waddr     = ADDR_W'(phys) * ADDR_W'(WIDTH) + ADDR_W'(col_q);

  always_comb begin
    busy_d = busy_q;
    base_d = base_q;
    row_d  = row_q;
    col_d  = col_q;
    vld_d  = vld_q;
    if (done_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      if (!is_cr) begin
        vld_d[waddr] = 1'b1;
      end
      if (wrap) begin
        col_d = '0;
        if (at_last_row) begin
          // scroll: rotate the top row to the bottom and blank it
          base_d = base_next;
          for (int r = 0; r < HEIGHT; r++) begin
            if (base_q == PH_W'(r)) begin
              vld_d[r*WIDTH +: WIDTH] = '0;
            end
          end
        end else begin
          row_d = row_q + PH_W'(1);
        end
      end else begin
        col_d = col_q + CC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
      base_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      vld_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      start_q <= accept;
      base_q  <= base_d;
      row_q   <= row_d;
      col_q   <= col_d;
      vld_q   <= vld_d;
    end
  end

  assign ram_we_o      = accept && !is_cr;
  assign ram_waddr_o   = waddr;
  assign ram_wdata_o   = rx_byte_i;
  assign vld_o         = vld_q;

  assign req_o.start         = start_q;
  assign req_o.base          = ROW_W'(base_q);
  assign req_o.cursor.row    = ROW_W'(row_q);
  assign req_o.cursor.column = COL_W'(col_q);

  `ASSERT_PROP(a_start_follows_xfer, clk_i, rst_ni, accept |=> start_q, "no redraw start")
  `ASSERT_PROP(a_start_while_busy, clk_i, rst_ni, start_q |-> busy_q, "start while idle")
  `ASSERT_NEVER(a_done_while_idle, clk_i, rst_ni, done_i && !busy_q, "redraw done while idle")
  `ASSERT_NEVER(a_row_range, clk_i, rst_ni, row_q > PH_W'(HEIGHT - 1), "cursor row out of range")

endmodule

>>> rtl/cdst_redraw.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdst_redraw #(
  parameter int WIDTH  = cdst_pkg::WIDTH_DEF,
  parameter int HEIGHT = cdst_pkg::HEIGHT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cdst_pkg::draw_req_t                   req_i,
  input  logic [HEIGHT*WIDTH-1:0]               vld_i,
  output logic                                  done_o,
  output logic                                  ram_re_o,
  output logic [$clog2(HEIGHT*WIDTH)-1:0]       ram_raddr_o,
  input  logic [cdst_pkg::GLYPH_W-1:0]          ram_rdata_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  kind_o,
  output logic [cdst_pkg::ROW_W-1:0]            row_o,
  output logic [cdst_pkg::COL_W-1:0]            column_o,
  output logic [cdst_pkg::GLYPH_W-1:0]          glyph_o,
  output logic                                  last_o
);
  import cdst_pkg::*;

  localparam int DEPTH  = HEIGHT * WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PH_W   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int CC_W   = $clog2(WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETPOS,
    S_WRITE,
    S_FINAL
  } seq_e;

  seq_e              state_q;
  logic [PH_W-1:0]   row_q;
  logic [CC_W-1:0]   col_q;
  logic              ovalid_q;
  logic              okind_q;
  logic [ROW_W-1:0]  orow_q;
  logic [COL_W-1:0]  ocol_q;
  logic              olast_q;
  logic              ovld_q;

  logic              adv;
  logic [ROW_W-1:0]  phys_full;
  logic [ADDR_W-1:0] raddr;

  assign adv       = (state_q != S_IDLE) && (!ovalid_q || !out_stall_i);
  assign phys_full = phys_row(req_i.base, ROW_W'(row_q), ROW_W'(HEIGHT));
  assign raddr     = ADDR_W'(phys_full[PH_W-1:0]) * ADDR_W'(WIDTH) + ADDR_W'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      ovalid_q <= 1'b0;
      okind_q  <= KIND_SETPOS;
      orow_q   <= '0;
      ocol_q   <= '0;
      olast_q  <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      if (!adv && ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            state_q <= S_SETPOS;
            row_q   <= '0;
          end
        end
        S_SETPOS: begin
          if (adv) begin
            ovalid_q <= 1'b1;
            okind_q  <= KIND_SETPOS;
            orow_q   <= ROW_W'(row_q);
            ocol_q   <= '0;
            olast_q  <= 1'b0;
            col_q    <= '0;
            state_q  <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (adv) begin
            ovalid_q <= 1'b1;
            okind_q  <= KIND_WRITE;
            orow_q   <= ROW_W'(row_q);
            ocol_q   <= COL_W'(col_q);
            olast_q  <= 1'b0;
            ovld_q   <= vld_i[raddr];
            if (col_q == CC_W'(WIDTH - 1)) begin
              if (row_q == PH_W'(HEIGHT - 1)) begin
                state_q <= S_FINAL;
              end else begin
                row_q   <= row_q + PH_W'(1);
                state_q <= S_SETPOS;
              end
            end else begin
              col_q <= col_q + CC_W'(1);
            end
          end
        end
        S_FINAL: begin
          if (adv) begin
            ovalid_q <= 1'b1;
            okind_q  <= KIND_SETPOS;
            orow_q   <= req_i.cursor.row;
            ocol_q   <= req_i.cursor.column;
            olast_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o      = adv && (state_q == S_FINAL);
  assign ram_re_o    = adv && (state_q == S_WRITE);
  assign ram_raddr_o = raddr;

  assign out_valid_o = ovalid_q;
  assign kind_o      = okind_q;
  assign row_o       = orow_q;
  assign column_o    = ocol_q;
  assign last_o      = olast_q;
  assign glyph_o     = (okind_q == KIND_WRITE) ? (ovld_q ? ram_rdata_i : CHAR_SPACE) : '0;

  `ASSERT_PROP(a_start_when_idle, clk_i, rst_ni, req_i.start |-> (state_q == S_IDLE), "busy start")
  `ASSERT_NEVER(a_last_on_write, clk_i, rst_ni, ovalid_q && olast_q && okind_q, "last on write")
  `ASSERT_NEVER(a_read_on_setpos, clk_i, rst_ni, ram_re_o && (state_q != S_WRITE), "read outside write step")

endmodule

>>> rtl/char_display_scroll_terminal_core.sv
// An input transfer sets start_q in the edit block; the redraw then enters S_SETPOS and
// registers its first transfer. No new byte is taken until that redraw has finished;
// it emits one result per cycle unless stalled, one read of the two-port RAM per glyph.
// Reset: cursor to row 0 column 0, every cell reads as a space, no clearing pass.
`timescale 1ns / 1ps
module char_display_scroll_terminal_core #(
  parameter int WIDTH  = cdst_pkg::WIDTH_DEF,
  parameter int HEIGHT = cdst_pkg::HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cdst_pkg::GLYPH_W-1:0] rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [cdst_pkg::ROW_W-1:0]   row_o,
  output logic [cdst_pkg::COL_W-1:0]   column_o,
  output logic [cdst_pkg::GLYPH_W-1:0] glyph_o,
  output logic                         last_o
);
  import cdst_pkg::*;

  localparam int DEPTH  = HEIGHT * WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  draw_req_t           req;
  logic [DEPTH-1:0]    vld;
  logic                done;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [GLYPH_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [GLYPH_W-1:0]  ram_rdata;

  cdst_edit #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_edit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .done_i     (done),
    .req_o      (req),
    .vld_o      (vld),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  cdst_ram #(
    .DW   (GLYPH_W),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cdst_redraw #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_redraw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .vld_i      (vld),
    .done_o     (done),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .row_o      (row_o),
    .column_o   (column_o),
    .glyph_o    (glyph_o),
    .last_o     (last_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cdst_pkg::*;

  localparam int SCR_W = WIDTH_DEF;
  localparam int SCR_H = HEIGHT_DEF;

  typedef struct packed {
    logic               kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [GLYPH_W-1:0] glyph;
    logic               last;
  } draw_op_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [GLYPH_W-1:0] rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic [ROW_W-1:0]   row_o;
  logic [COL_W-1:0]   column_o;
  logic [GLYPH_W-1:0] glyph_o;
  logic               last_o;

  logic [SCR_W-1:0][GLYPH_W-1:0] screen_rows [SCR_H];
  logic [ROW_W-1:0]              cur_row;
  logic [COL_W-1:0]              cur_col;
  draw_op_t                      redraw_q [$];
  draw_op_t                      due_op;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit rx_hold = 1'b0;
  int rx_wait = 0;
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;

  char_display_scroll_terminal_core #(
    .WIDTH (SCR_W),
    .HEIGHT(SCR_H)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .row_o      (row_o),
    .column_o   (column_o),
    .glyph_o    (glyph_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic void feed_line();
    cur_col = '0;
    if (cur_row == SCR_H - 1) begin
      for (int r = 0; r < SCR_H - 1; r++) screen_rows[r] = screen_rows[r + 1];
      screen_rows[SCR_H - 1] = {SCR_W{CHAR_SPACE}};
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endfunction

  task automatic apply_rx_byte(input logic [GLYPH_W-1:0] b);
    if (b == CHAR_CR) begin
      feed_line();
    end else begin
      screen_rows[cur_row][cur_col] = b;
      if (cur_col == SCR_W - 1) begin
        feed_line();
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end
    for (int r = 0; r < SCR_H; r++) begin
      redraw_q.push_back('{kind: KIND_SETPOS, row: ROW_W'(r), column: '0, glyph: '0,
                           last: 1'b0});
      for (int c = 0; c < SCR_W; c++) begin
        redraw_q.push_back('{kind: KIND_WRITE, row: ROW_W'(r), column: COL_W'(c),
                             glyph: screen_rows[r][c], last: 1'b0});
      end
    end
    redraw_q.push_back('{kind: KIND_SETPOS, row: cur_row, column: cur_col, glyph: '0,
                         last: 1'b1});
  endtask

  task automatic check_field(input string name, input logic [7:0] expected,
                             input logic [7:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (redraw_q.size() == 0) begin
        $display({"%0t: unexpected transfer, expected none, ",
                  "actual kind %0d row %0d column %0d glyph %0d last %0d"},
                 $time, kind_o, row_o, column_o, glyph_o, last_o);
        err_count++;
      end else begin
        due_op = redraw_q.pop_front();
        check_field("kind", 8'(due_op.kind), 8'(kind_o));
        check_field("row", 8'(due_op.row), 8'(row_o));
        check_field("column", 8'(due_op.column), 8'(column_o));
        check_field("glyph", due_op.glyph, glyph_o);
        check_field("last", 8'(due_op.last), 8'(last_o));
      end
      rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
    end
    if (rx_hold || rx_wait > 0) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if (rx_wait > 0) rx_wait--;
  end

  task automatic send_rx_byte(input logic [GLYPH_W-1:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    apply_rx_byte(b);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_byte_extremes();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(CHAR_CR - 8'd1);
    send_rx_byte(CHAR_CR + 8'd1);
    idle_input();
  endtask

  task automatic test_cr_scroll();
    send_rx_byte(CHAR_CR);
    send_rx_byte(8'h80);
    send_rx_byte(8'h7F);
    send_rx_byte(CHAR_CR);
    send_rx_byte(CHAR_CR);
    idle_input();
  endtask

  task automatic test_last_column_wrap();
    logic [GLYPH_W-1:0] walk;
    for (int k = 0; k < SCR_W; k++) begin
      walk = 8'h01 << (k % 8);
      send_rx_byte(k < 8 ? walk : ~walk);
    end
    idle_input();
  endtask

  task automatic test_output_pressure();
    tx_idle = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (600) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        for (int k = 0; k < 8; k++) send_rx_byte(8'($urandom_range(0, 255)));
        idle_input();
      end
    join
    tx_idle = 1'b1;
  endtask

  task automatic test_random_text();
    int cr_odds;
    int pick;
    logic [GLYPH_W-1:0] b;
    for (int batch = 0; batch < 7; batch++) begin
      tx_idle = (batch != 1 && batch != 3 && batch != 6);
      rx_idle <= (batch != 2 && batch != 3);
      cr_odds = (batch % 2 == 0) ? 6 : 40;
      for (int k = 0; k < 36; k++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(1, cr_odds) == 1) begin
          b = CHAR_CR;
        end else if (pick < 20) begin
          b = 8'($urandom_range(0, 255));
        end else begin
          b = 8'($urandom_range(8'h20, 8'h7E));
        end
        send_rx_byte(b);
      end
    end
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    idle_input();
  endtask

  initial begin
    for (int r = 0; r < SCR_H; r++) screen_rows[r] = {SCR_W{CHAR_SPACE}};
    cur_row = '0;
    cur_col = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_byte_extremes();
    test_cr_scroll();
    test_last_column_wrap();
    test_output_pressure();
    test_random_text();
    while (redraw_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d received bytes and %0d redraw transfers, with wraps, scrolls,",
             items_sent, results_seen);
    $display("carriage returns on every row and a long output hold-off.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #7_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> char_display_scroll_terminal_core.f
+incdir+rtl
rtl/cdst_pkg.sv
rtl/cdst_ram.sv
rtl/cdst_edit.sv
rtl/cdst_redraw.sv
rtl/char_display_scroll_terminal_core.sv
sim/testbench.sv
